// ===== sv/slp_pkg.sv =====
// Shared constants, types and saturation helper for the simplex solver.
package slp_pkg;

    localparam int SLP_MAX_VARS    = 64;
    localparam int SLP_MAX_CONS    = 64;
    localparam int SLP_FRAC_BITS   = 16;
    localparam int SLP_PIVOT_LIMIT = 1024;

    localparam logic CFG_NUM_VARS = 1'b0;
    localparam logic CFG_NUM_CONS = 1'b1;

    localparam logic STATUS_OPTIMAL   = 1'b0;
    localparam logic STATUS_UNBOUNDED = 1'b1;

    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic signed [31:0] den;
    } slp_div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quot;
    } slp_div_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [64:0] x);
        logic signed [31:0] r;
        if (x > 65'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (x < -65'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

// ===== sv/slp_if.sv =====
// Handshake channels of the simplex solver: configuration, entry and result.
interface slp_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [6:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

interface slp_entry_if;
    logic               valid;
    logic               ready;
    logic [6:0]         row;
    logic [6:0]         col;
    logic signed [31:0] entry_value;
    logic               last;
    modport source (output valid, row, col, entry_value, last, input ready);
    modport sink (input valid, row, col, entry_value, last, output ready);
endinterface

interface slp_result_if;
    logic               valid;
    logic               ready;
    logic               status;
    logic signed [31:0] objective_value;
    modport source (output valid, status, objective_value, input ready);
    modport sink (input valid, status, objective_value, output ready);
endinterface

// ===== sv/simplex_lp_solver_unit.sv =====
// Simplex linear-program solver top level: tableau store, pivot sequencer, result port.
// Entries load one item per cycle into a (MAX_CONS+1) x (MAX_VARS+1) tableau memory
// with one write and one read port (row 0 objective, column 0 right-hand side). The item
// marked last starts the solve and entry stalls until the result is delivered and the
// memory is swept back to zero. One read port with a registered output, one shared 32x32
// multiplier and one bit-serial divider do all the work. A divide holds the sequencer
// until the divider reports done, so the solve time is set by memory reads and divides,
// at most 1024 pivots. After reset and after every result a clearing pass that writes
// zero to all (MAX_CONS+1)*(MAX_VARS+1) entries (4225 by default) runs while no item is
// accepted; configuration writes are taken at any time.
module simplex_lp_solver_unit
    import slp_pkg::*;
#(
    parameter int MAX_VARS  = SLP_MAX_VARS,
    parameter int MAX_CONS  = SLP_MAX_CONS,
    parameter int FRAC_BITS = SLP_FRAC_BITS
)
(
    input  logic           clk,
    input  logic           rst_n,
    slp_cfg_if.sink        cfg,
    slp_entry_if.sink      entry,
    slp_result_if.source   result
);

    localparam int RW    = $clog2(MAX_CONS + 1);
    localparam int CW    = $clog2(MAX_VARS + 1);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;
    localparam int ITW   = $clog2(SLP_PIVOT_LIMIT);
    localparam logic signed [31:0] ONE = 32'(64'd1 << FRAC_BITS);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_CLR    = 5'd1;
    localparam logic [4:0] ST_COL_RD = 5'd2;
    localparam logic [4:0] ST_COL_EV = 5'd3;
    localparam logic [4:0] ST_RT_RD  = 5'd4;
    localparam logic [4:0] ST_RT_EV  = 5'd5;
    localparam logic [4:0] ST_RR_RD  = 5'd6;
    localparam logic [4:0] ST_RR_EV  = 5'd7;
    localparam logic [4:0] ST_RDIV   = 5'd8;
    localparam logic [4:0] ST_RNEXT  = 5'd9;
    localparam logic [4:0] ST_PV_RD  = 5'd10;
    localparam logic [4:0] ST_PV_EV  = 5'd11;
    localparam logic [4:0] ST_N_RD   = 5'd12;
    localparam logic [4:0] ST_N_EV   = 5'd13;
    localparam logic [4:0] ST_NDIV   = 5'd14;
    localparam logic [4:0] ST_E_ROW  = 5'd15;
    localparam logic [4:0] ST_F_RD   = 5'd16;
    localparam logic [4:0] ST_F_EV   = 5'd17;
    localparam logic [4:0] ST_A_RD   = 5'd18;
    localparam logic [4:0] ST_A_EV   = 5'd19;
    localparam logic [4:0] ST_B_RD   = 5'd20;
    localparam logic [4:0] ST_B_EV   = 5'd21;
    localparam logic [4:0] ST_UPD    = 5'd22;
    localparam logic [4:0] ST_E_NEXT = 5'd23;
    localparam logic [4:0] ST_DONE   = 5'd24;

    logic [4:0]         state_reg;
    logic [6:0]         num_vars_reg;
    logic [6:0]         num_cons_reg;
    logic [CW-1:0]      nv_reg;
    logic [RW-1:0]      nc_reg;
    logic [RW-1:0]      i_reg;
    logic [CW-1:0]      j_reg;
    logic [CW-1:0]      ec_reg;
    logic [RW-1:0]      lr_reg;
    logic [ITW-1:0]     iter_reg;
    logic               have_row_reg;
    logic signed [31:0] best_reg;
    logic signed [31:0] coef_reg;
    logic signed [31:0] f_reg;
    logic signed [31:0] a_reg;
    logic signed [31:0] b_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] acc_reg;
    logic               status_reg;
    logic               out_valid_reg;
    logic               out_status_reg;
    logic signed [31:0] out_obj_reg;
    logic signed [31:0] mem_q_reg;

    logic signed [31:0] mem [DEPTH];

    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic signed [31:0] mem_wd;
    logic [AW-1:0]      rd_addr;

    slp_div_req_t       div_req;
    slp_div_rsp_t       div_rsp;

    logic [8:0]         row_x;
    logic [8:0]         col_x;
    logic               in_range;
    logic               entry_acc;
    logic [8:0]         nv_x;
    logic [8:0]         nc_x;
    logic [CW-1:0]      nv_clamp;
    logic [RW-1:0]      nc_clamp;
    logic signed [31:0] t_sat;
    logic signed [31:0] diff_val;
    logic signed [31:0] neg_val;
    logic signed [31:0] acc_sum;
    logic               obj_rhs;

    slp_div #(.FRAC_BITS(FRAC_BITS)) u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cfg.ready     = 1'b1;
    assign entry.ready   = (state_reg == ST_IDLE) && !out_valid_reg;
    assign entry_acc     = entry.valid && entry.ready;
    assign result.valid  = out_valid_reg;
    assign result.status = out_status_reg;
    assign result.objective_value = out_obj_reg;

    assign row_x    = 9'(entry.row);
    assign col_x    = 9'(entry.col);
    assign in_range = (row_x <= 9'(MAX_CONS)) && (col_x <= 9'(MAX_VARS))
                      && !((row_x == 9'd0) && (col_x == 9'd0));

    assign nv_x     = 9'(num_vars_reg);
    assign nc_x     = 9'(num_cons_reg);
    assign nv_clamp = (nv_x == 9'd0) ? CW'(1) :
                      (nv_x > 9'(MAX_VARS)) ? CW'(MAX_VARS) : CW'(nv_x);
    assign nc_clamp = (nc_x == 9'd0) ? RW'(1) :
                      (nc_x > 9'(MAX_CONS)) ? RW'(MAX_CONS) : RW'(nc_x);

    // product scaled back with floor rounding, then the row update forms
    assign t_sat    = sat32(65'(prod_reg >>> FRAC_BITS));
    assign diff_val = sat32(65'(b_reg) - 65'(t_sat));
    assign neg_val  = sat32(-65'(t_sat));
    assign acc_sum  = sat32(65'(acc_reg) + 65'(t_sat));
    assign obj_rhs  = (i_reg == RW'(0)) && (j_reg == CW'(0));

    always_comb
    begin
        unique case (state_reg)
            ST_COL_RD: rd_addr = {RW'(0), j_reg};
            ST_RT_RD:  rd_addr = {i_reg, ec_reg};
            ST_RR_RD:  rd_addr = {i_reg, CW'(0)};
            ST_PV_RD:  rd_addr = {lr_reg, ec_reg};
            ST_N_RD:   rd_addr = {lr_reg, j_reg};
            ST_F_RD:   rd_addr = {i_reg, ec_reg};
            ST_A_RD:   rd_addr = {lr_reg, j_reg};
            ST_B_RD:   rd_addr = {i_reg, j_reg};
            default:   rd_addr = '0;
        endcase
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = {i_reg, j_reg};
        mem_wd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                mem_we = entry_acc && in_range;
                mem_wa = {RW'(row_x), CW'(col_x)};
                mem_wd = entry.entry_value;
            end
            ST_CLR:
            begin
                mem_we = 1'b1;
            end
            ST_NDIV:
            begin
                mem_we = div_rsp.done;
                mem_wa = {lr_reg, j_reg};
                mem_wd = div_rsp.quot;
            end
            ST_UPD:
            begin
                mem_we = !obj_rhs;
                mem_wd = (j_reg == ec_reg) ? neg_val : diff_val;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        div_req.start = (state_reg == ST_RR_EV) || (state_reg == ST_N_EV);
        div_req.den   = coef_reg;
        if ((state_reg == ST_N_EV) && (j_reg == ec_reg))
            div_req.num = ONE;
        else
            div_req.num = mem_q_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        mem_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            num_vars_reg   <= 7'd1;
            num_cons_reg   <= 7'd1;
            nv_reg         <= CW'(1);
            nc_reg         <= RW'(1);
            i_reg          <= '0;
            j_reg          <= '0;
            ec_reg         <= '0;
            lr_reg         <= '0;
            iter_reg       <= '0;
            have_row_reg   <= 1'b0;
            acc_reg        <= '0;
            status_reg     <= STATUS_OPTIMAL;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_OPTIMAL;
            out_obj_reg    <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_NUM_VARS: num_vars_reg <= cfg.data;
                    CFG_NUM_CONS: num_cons_reg <= cfg.data;
                endcase
            end
            if (result.valid && result.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_CLR:
                begin
                    if (j_reg == CW'(MAX_VARS))
                    begin
                        j_reg <= '0;
                        if (i_reg == RW'(MAX_CONS))
                        begin
                            i_reg     <= '0;
                            state_reg <= ST_IDLE;
                        end
                        else
                            i_reg <= i_reg + RW'(1);
                    end
                    else
                        j_reg <= j_reg + CW'(1);
                end
                ST_IDLE:
                begin
                    if (entry_acc && entry.last)
                    begin
                        nv_reg    <= nv_clamp;
                        nc_reg    <= nc_clamp;
                        iter_reg  <= '0;
                        j_reg     <= CW'(1);
                        state_reg <= ST_COL_RD;
                    end
                end
                ST_COL_RD: state_reg <= ST_COL_EV;
                ST_COL_EV:
                begin
                    // first objective column above zero enters
                    if (mem_q_reg > 32'sd0)
                    begin
                        ec_reg       <= j_reg;
                        i_reg        <= RW'(1);
                        have_row_reg <= 1'b0;
                        state_reg    <= ST_RT_RD;
                    end
                    else if (j_reg == nv_reg)
                    begin
                        status_reg <= STATUS_OPTIMAL;
                        state_reg  <= ST_DONE;
                    end
                    else
                    begin
                        j_reg     <= j_reg + CW'(1);
                        state_reg <= ST_COL_RD;
                    end
                end
                ST_RT_RD: state_reg <= ST_RT_EV;
                ST_RT_EV:
                begin
                    if (mem_q_reg > 32'sd0)
                    begin
                        coef_reg  <= mem_q_reg;
                        state_reg <= ST_RR_RD;
                    end
                    else
                        state_reg <= ST_RNEXT;
                end
                ST_RR_RD: state_reg <= ST_RR_EV;
                ST_RR_EV: state_reg <= ST_RDIV;
                ST_RDIV:
                begin
                    if (div_rsp.done)
                    begin
                        // strict compare keeps the first row on ties
                        if (!have_row_reg || (div_rsp.quot < best_reg))
                        begin
                            have_row_reg <= 1'b1;
                            best_reg     <= div_rsp.quot;
                            lr_reg       <= i_reg;
                        end
                        state_reg <= ST_RNEXT;
                    end
                end
                ST_RNEXT:
                begin
                    if (i_reg == nc_reg)
                    begin
                        if (have_row_reg)
                            state_reg <= ST_PV_RD;
                        else
                        begin
                            status_reg <= STATUS_UNBOUNDED;
                            state_reg  <= ST_DONE;
                        end
                    end
                    else
                    begin
                        i_reg     <= i_reg + RW'(1);
                        state_reg <= ST_RT_RD;
                    end
                end
                ST_PV_RD: state_reg <= ST_PV_EV;
                ST_PV_EV:
                begin
                    coef_reg  <= mem_q_reg;
                    j_reg     <= '0;
                    state_reg <= ST_N_RD;
                end
                ST_N_RD: state_reg <= ST_N_EV;
                ST_N_EV: state_reg <= ST_NDIV;
                ST_NDIV:
                begin
                    if (div_rsp.done)
                    begin
                        if (j_reg == nv_reg)
                        begin
                            i_reg     <= '0;
                            state_reg <= ST_E_ROW;
                        end
                        else
                        begin
                            j_reg     <= j_reg + CW'(1);
                            state_reg <= ST_N_RD;
                        end
                    end
                end
                ST_E_ROW:
                begin
                    if (i_reg == lr_reg)
                        state_reg <= ST_E_NEXT;
                    else
                        state_reg <= ST_F_RD;
                end
                ST_F_RD: state_reg <= ST_F_EV;
                ST_F_EV:
                begin
                    f_reg     <= mem_q_reg;
                    j_reg     <= '0;
                    state_reg <= ST_A_RD;
                end
                ST_A_RD: state_reg <= ST_A_EV;
                ST_A_EV:
                begin
                    a_reg     <= mem_q_reg;
                    state_reg <= ST_B_RD;
                end
                ST_B_RD: state_reg <= ST_B_EV;
                ST_B_EV:
                begin
                    b_reg     <= mem_q_reg;
                    prod_reg  <= f_reg * a_reg;
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    // objective row, rhs column accumulates instead of storing
                    if (obj_rhs)
                        acc_reg <= acc_sum;
                    if (j_reg == nv_reg)
                        state_reg <= ST_E_NEXT;
                    else
                    begin
                        j_reg     <= j_reg + CW'(1);
                        state_reg <= ST_A_RD;
                    end
                end
                ST_E_NEXT:
                begin
                    if (i_reg == nc_reg)
                    begin
                        if (iter_reg == ITW'(SLP_PIVOT_LIMIT - 1))
                        begin
                            status_reg <= STATUS_OPTIMAL;
                            state_reg  <= ST_DONE;
                        end
                        else
                        begin
                            iter_reg  <= iter_reg + ITW'(1);
                            j_reg     <= CW'(1);
                            state_reg <= ST_COL_RD;
                        end
                    end
                    else
                    begin
                        i_reg     <= i_reg + RW'(1);
                        state_reg <= ST_E_ROW;
                    end
                end
                ST_DONE:
                begin
                    out_valid_reg  <= 1'b1;
                    out_status_reg <= status_reg;
                    out_obj_reg    <= acc_reg;
                    acc_reg        <= '0;
                    i_reg          <= '0;
                    j_reg          <= '0;
                    state_reg      <= ST_CLR;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_RDIV) || (state_reg == ST_NDIV))
        else $error("divider finished outside a wait state");

    a_result_then_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (state_reg == ST_CLR) && (acc_reg == 32'sd0))
        else $error("result raised without starting the clearing pass");

    a_no_entry_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (entry.valid && entry.ready) |-> !out_valid_reg && (state_reg == ST_IDLE))
        else $error("item taken while a result is pending");
`endif

endmodule

// ===== sv/slp_div.sv =====
// Bit-serial fixed-point divider: floor((num << FRAC_BITS) / den), den > 0, saturated.
module slp_div
    import slp_pkg::*;
#(
    parameter int FRAC_BITS = SLP_FRAC_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  slp_div_req_t req,
    output slp_div_rsp_t rsp
);

    localparam int W    = 32 + FRAC_BITS;
    localparam int CNTW = $clog2(W + 1);

    logic              busy_reg;
    logic              fin_reg;
    logic              done_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic              neg_reg;
    logic [W-1:0]      n_reg;
    logic [W-1:0]      q_reg;
    logic [32:0]       r_reg;
    logic [31:0]       den_reg;
    logic signed [31:0] quot_reg;

    logic [31:0] mag;
    logic [32:0] r_sh;
    logic        q_bit;
    logic [W:0]  q_up;

    assign mag   = req.num[31] ? 32'(-33'(req.num)) : 32'(req.num);
    assign r_sh  = {r_reg[31:0], n_reg[W-1]};
    assign q_bit = (r_sh >= {1'b0, den_reg});
    assign q_up  = (W+1)'(q_reg) + (W+1)'(neg_reg && (r_reg != 33'd0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg <= req.num[31];
            n_reg   <= {mag, {FRAC_BITS{1'b0}}};
            r_reg   <= '0;
            q_reg   <= '0;
            den_reg <= 32'(req.den);
        end
        else if (busy_reg)
        begin
            r_reg <= q_bit ? (r_sh - {1'b0, den_reg}) : r_sh;
            q_reg <= {q_reg[W-2:0], q_bit};
            n_reg <= {n_reg[W-2:0], 1'b0};
        end
        else if (fin_reg)
        begin
            // apply sign, round toward minus infinity, clamp
            if (!neg_reg)
                quot_reg <= (q_reg > W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(q_reg[31:0]);
            else if (q_up > (W+1)'(33'h0_8000_0000))
                quot_reg <= 32'sh8000_0000;
            else
                quot_reg <= $signed(32'(-q_up));
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// ===== sim/tb_slp_pkg.sv =====
// Testbench-side types for the simplex solver check: expected result and stimulus row.
package tb_slp_pkg;
    import slp_pkg::*;

    typedef struct packed {
        logic               status;
        logic signed [31:0] objective_value;
    } lp_outcome_t;

    typedef struct packed {
        bit         is_cfg;
        logic [6:0] row;
        logic [6:0] col;
        logic [31:0] entry_value;
        bit         last;
        bit         typed;
        logic       status;
        logic [31:0] objective_value;
    } stim_row_t;
endpackage

// ===== sim/testbench.sv =====
// Top-level check of simplex_lp_solver_unit: directed table, random programs, own solver.
module testbench
    import slp_pkg::*, tb_slp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_TARGET = 1950;
    localparam int QUIET_AFTER  = 1800;
    localparam int NDIR         = 34;

    // row holds the register index on configuration rows, col holds the data
    localparam stim_row_t DIRECTED [NDIR] = '{
        '{1'b1, 7'(CFG_NUM_VARS), 7'd2, 32'h0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b1, 7'(CFG_NUM_CONS), 7'd2, 32'h0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b0, 7'd0, 7'd0, 32'd5, 1'b1, 1'b1, STATUS_OPTIMAL, 32'h0},
        '{1'b0, 7'd0, 7'd1, 32'h0001_0000, 1'b1, 1'b1, STATUS_UNBOUNDED, 32'h0},
        '{1'b0, 7'd0, 7'd1, 32'h0002_0000, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b0, 7'd1, 7'd1, 32'h0001_0000, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b0, 7'd1, 7'd0, 32'h0004_0000, 1'b1, 1'b1, STATUS_OPTIMAL, 32'h0008_0000},
        '{1'b0, 7'd0, 7'd1, 32'h0001_0000, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b0, 7'd1, 7'd1, 32'h0001_0000, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b0, 7'd1, 7'd0, 32'hFFFE_0000, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b0, 7'd2, 7'd1, 32'h0001_0000, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b0, 7'd2, 7'd0, 32'h0003_0000, 1'b1, 1'b0, 1'b0, 32'h0},
        '{1'b0, 7'd100, 7'd3, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b0, 7'd3, 7'd127, 32'h1234_5678, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b0, 7'd65, 7'd65, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b0, 7'd0, 7'd2, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b0, 7'd1, 7'd2, 32'h0000_0001, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b0, 7'd1, 7'd0, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0},
        '{1'b1, 7'(CFG_NUM_VARS), 7'd0, 32'h0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b1, 7'(CFG_NUM_CONS), 7'd127, 32'h0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b0, 7'd64, 7'd64, 32'h0001_0000, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b0, 7'd0, 7'd1, 32'h0001_0000, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b0, 7'd64, 7'd1, 32'h0000_8000, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b0, 7'd64, 7'd0, 32'h0001_0000, 1'b1, 1'b0, 1'b0, 32'h0},
        '{1'b1, 7'(CFG_NUM_VARS), 7'd64, 32'h0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b1, 7'(CFG_NUM_CONS), 7'd64, 32'h0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b0, 7'd0, 7'd64, 32'h0001_0000, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b0, 7'd64, 7'd64, 32'h0002_0000, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b0, 7'd64, 7'd0, 32'h8000_0000, 1'b1, 1'b0, 1'b0, 32'h0},
        '{1'b1, 7'(CFG_NUM_VARS), 7'd127, 32'h0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b1, 7'(CFG_NUM_CONS), 7'd0, 32'h0, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b0, 7'd0, 7'd64, 32'h0001_0000, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b0, 7'd1, 7'd64, 32'h0001_0000, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b0, 7'd1, 7'd0, 32'h0005_0000, 1'b1, 1'b0, 1'b0, 32'h0}
    };

    logic clk;
    logic rst_n;

    slp_cfg_if    cfg_ch ();
    slp_entry_if  entry_ch ();
    slp_result_if result_ch ();

    simplex_lp_solver_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch.sink),
        .entry  (entry_ch.sink),
        .result (result_ch.source)
    );

    // mirror of the block's program store and registers
    int          coef [SLP_MAX_CONS][SLP_MAX_VARS];
    int          rhs [SLP_MAX_CONS];
    int          cost [SLP_MAX_VARS];
    int          obj_acc;
    int unsigned vars_reg;
    int unsigned cons_reg;

    lp_outcome_t pending_outcomes [$];
    int          errors;
    int          items_sent;
    bit          quiet;
    bit          hold_req;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        #(100_000_000);
        $display("simplex_lp_solver_unit test failed");
        $finish;
    end

    function automatic int fx_sat(longint x);
        if (x > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (x < -64'sd2147483648)
            return 32'sh8000_0000;
        return int'(x);
    endfunction

    function automatic longint floor_quot(longint num, longint den);
        if (num >= 0)
            return num / den;
        return -((-num + den - 1) / den);
    endfunction

    function automatic int fx_mul(int a, int b);
        return fx_sat(floor_quot(longint'(a) * longint'(b), 64'sd1 << SLP_FRAC_BITS));
    endfunction

    function automatic int fx_div(int a, int b);
        return fx_sat(floor_quot(longint'(a) * (64'sd1 << SLP_FRAC_BITS), longint'(b)));
    endfunction

    function automatic void clear_program();
        foreach (coef[i, j]) coef[i][j] = 0;
        foreach (rhs[i]) rhs[i] = 0;
        foreach (cost[j]) cost[j] = 0;
        obj_acc = 0;
    endfunction

    function automatic void pivot_tableau(int nv, int nc, int lr, int ec);
        int p;
        int f;
        p = coef[lr][ec];
        rhs[lr] = fx_div(rhs[lr], p);
        for (int j = 0; j < nv; j++)
            if (j != ec) coef[lr][j] = fx_div(coef[lr][j], p);
        coef[lr][ec] = fx_div(32'sh0001_0000, p);
        for (int i = 0; i < nc; i++)
        begin
            if (i == lr) continue;
            f = coef[i][ec];
            rhs[i] = fx_sat(longint'(rhs[i]) - fx_mul(f, rhs[lr]));
            for (int j = 0; j < nv; j++)
                if (j != ec) coef[i][j] = fx_sat(longint'(coef[i][j]) - fx_mul(f, coef[lr][j]));
            coef[i][ec] = fx_sat(-longint'(fx_mul(f, coef[lr][ec])));
        end
        obj_acc = fx_sat(longint'(obj_acc) + fx_mul(cost[ec], rhs[lr]));
        for (int j = 0; j < nv; j++)
            if (j != ec) cost[j] = fx_sat(longint'(cost[j]) - fx_mul(cost[ec], coef[lr][j]));
        cost[ec] = fx_sat(-longint'(fx_mul(cost[ec], coef[lr][ec])));
    endfunction

    function automatic lp_outcome_t solve_program();
        int nv;
        int nc;
        int ec;
        int lr;
        int best;
        int r;
        bit have_col;
        bit have_row;
        lp_outcome_t res;
        nv = (vars_reg < 1) ? 1 : (vars_reg > SLP_MAX_VARS) ? SLP_MAX_VARS : vars_reg;
        nc = (cons_reg < 1) ? 1 : (cons_reg > SLP_MAX_CONS) ? SLP_MAX_CONS : cons_reg;
        res.status = STATUS_OPTIMAL;
        for (int it = 0; it < SLP_PIVOT_LIMIT; it++)
        begin
            have_col = 1'b0;
            have_row = 1'b0;
            ec = 0;
            lr = 0;
            best = 0;
            for (int j = 0; j < nv; j++)
                if (cost[j] > 0)
                begin
                    have_col = 1'b1;
                    ec = j;
                    break;
                end
            if (!have_col) break;
            for (int i = 0; i < nc; i++)
                if (coef[i][ec] > 0)
                begin
                    r = fx_div(rhs[i], coef[i][ec]);
                    if (!have_row || r < best)
                    begin
                        have_row = 1'b1;
                        best = r;
                        lr = i;
                    end
                end
            if (!have_row)
            begin
                res.status = STATUS_UNBOUNDED;
                break;
            end
            pivot_tableau(nv, nc, lr, ec);
        end
        res.objective_value = obj_acc;
        clear_program();
        return res;
    endfunction

    task automatic write_reg(logic index, logic [6:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        if (index == CFG_NUM_VARS)
            vars_reg = data;
        else
            cons_reg = data;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // offer one item, hold it until taken, update the mirror, then maybe idle
    task automatic put_entry(stim_row_t s);
        lp_outcome_t res;
        entry_ch.valid       <= 1'b1;
        entry_ch.row         <= s.row;
        entry_ch.col         <= s.col;
        entry_ch.entry_value <= s.entry_value;
        entry_ch.last        <= s.last;
        do @(posedge clk); while (!entry_ch.ready);
        items_sent++;
        if (s.row <= SLP_MAX_CONS && s.col <= SLP_MAX_VARS)
        begin
            if (s.row == 0)
            begin
                if (s.col != 0) cost[s.col - 1] = s.entry_value;
            end
            else if (s.col == 0)
                rhs[s.row - 1] = s.entry_value;
            else
                coef[s.row - 1][s.col - 1] = s.entry_value;
        end
        if (s.last)
        begin
            res = solve_program();
            if (s.typed)
            begin
                res.status = s.status;
                res.objective_value = s.objective_value;
            end
            pending_outcomes.push_back(res);
        end
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            entry_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        entry_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_outcomes.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // compare each delivered result against the oldest expectation
    always @(posedge clk)
    begin
        lp_outcome_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("unexpected result: status %0d objective_value %h",
                       result_ch.status, result_ch.objective_value);
                errors++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (result_ch.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, result_ch.status);
                    errors++;
                end
                if (result_ch.objective_value !== want.objective_value)
                begin
                    $error("objective_value: expected %h, actual %h",
                           want.objective_value, result_ch.objective_value);
                    errors++;
                end
            end
        end
    end

    // result-side backpressure: random bursts, one long hold-off, none at the end
    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (quiet)
                result_ch.ready <= 1'b1;
            else if (hold_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_req = 1'b0;
                result_ch.ready <= 1'b1;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(posedge clk);
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        stim_row_t s;
        int nv;
        int nc;
        int count;
        errors = 0;
        items_sent = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_NUM_VARS;
        cfg_ch.data = '0;
        entry_ch.valid = 1'b0;
        entry_ch.row = '0;
        entry_ch.col = '0;
        entry_ch.entry_value = '0;
        entry_ch.last = 1'b0;
        clear_program();
        vars_reg = 1;
        cons_reg = 1;
        nv = 1;
        nc = 1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[k])
        begin
            if (DIRECTED[k].is_cfg)
            begin
                wait_drained();
                write_reg(DIRECTED[k].row[0], DIRECTED[k].col);
            end
            else
                put_entry(DIRECTED[k]);
        end

        hold_req = 1'b1;
        while (items_sent < ITEMS_TARGET)
        begin
            if (items_sent > QUIET_AFTER) quiet = 1'b1;
            // while results are held off, keep the registers and offer the next program
            if (!(hold_req && pending_outcomes.size() != 0))
            begin
                wait_drained();
                if ($urandom_range(0, 19) == 0)
                begin
                    nv = $urandom_range(0, 1) ? 0 : ($urandom_range(0, 1) ? 64 : 127);
                    nc = $urandom_range(0, 1) ? 1 : ($urandom_range(0, 1) ? 64 : 127);
                end
                else
                begin
                    nv = $urandom_range(1, 4);
                    nc = $urandom_range(1, 4);
                end
                write_reg(CFG_NUM_VARS, 7'(nv));
                write_reg(CFG_NUM_CONS, 7'(nc));
            end
            if (nv > 8 || nc > 8)
                count = $urandom_range(2, 8);
            else
                count = $urandom_range(2, (nv + 1) * (nc + 1) + 2);
            for (int n = 0; n < count; n++)
            begin
                s = '0;
                if ($urandom_range(0, 99) < 85)
                begin
                    s.row = $urandom_range(0, (nc > 64) ? 64 : nc);
                    s.col = $urandom_range(0, (nv > 64) ? 64 : nv);
                    if (s.row == 0)
                        s.entry_value = $urandom_range(1, 32'h4_0000);
                    else if (s.col == 0)
                        s.entry_value = $urandom_range(0, 32'h10_0000);
                    else
                        s.entry_value = $urandom_range(32'h100, 32'h4_0000);
                    if ($urandom_range(0, 9) == 0)
                        s.entry_value = -s.entry_value;
                end
                else
                begin
                    s.row = $urandom_range(0, 127);
                    s.col = $urandom_range(0, 127);
                    s.entry_value = $urandom;
                end
                s.last = (n == count - 1);
                put_entry(s);
            end
        end

        quiet = 1'b1;
        entry_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_outcomes.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("simplex_lp_solver_unit test passed");
        else
            $display("simplex_lp_solver_unit test failed");
        $finish;
    end
endmodule
